[rtl/core/serial_alphanumeric_display_controller_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the serial alphanumeric display controller
// Shared concurrent assertion forms, all disabled while in reset.
// ---------------------------------------------------------------------------
`ifndef SERIAL_ALPHANUMERIC_DISPLAY_CONTROLLER_ASSERT_SVH
`define SERIAL_ALPHANUMERIC_DISPLAY_CONTROLLER_ASSERT_SVH

// condition holds whenever out of reset
`define SADC_ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define SADC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define SADC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/core/sadc_pkg.sv]
// ---------------------------------------------------------------------------
// sadc_pkg
// Types, codes and the segment table of the display controller.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package sadc_pkg;

  localparam int NUM_DIGITS = 16;

  // commands
  typedef enum logic [1:0] {
    CMD_ENABLE = 2'd0,
    CMD_PINS   = 2'd1,
    CMD_BYTE   = 2'd2,
    CMD_NOP    = 2'd3
  } sadc_cmd_t;

  // byte classes by the top three bits
  localparam logic [2:0] TOP_INTENSITY = 3'b111;
  localparam logic [2:0] TOP_CURSOR    = 3'b101;
  localparam logic [2:0] TOP_DIGITS    = 3'b110;
  localparam logic [2:0] TOP_TEST      = 3'b100;

  localparam logic [5:0] CODE_SPACE  = 6'h20;
  localparam logic [5:0] CODE_PERIOD = 6'h2E;
  localparam logic [5:0] CODE_COMMA  = 6'h2C;
  localparam logic [7:0] DOT_NONE    = 8'h00;

  localparam logic [3:0] CURSOR_RESET = 4'd15;
  localparam logic [4:0] DIGITS_MAX   = 5'(NUM_DIGITS);

  typedef struct packed {
    logic [1:0] cmd;
    logic       level;
    logic [7:0] data;
    logic [3:0] read_index;
  } sadc_in_t;

  typedef struct packed {
    logic [5:0]  char_code;
    logic [7:0]  dot_comma;
    logic [15:0] segments;
    logic [4:0]  intensity;
    logic [4:0]  digit_count;
    logic [3:0]  cursor;
    logic        enabled;
  } sadc_out_t;

  // settings after an item's update
  typedef struct packed {
    logic       enabled;
    logic [3:0] cursor;
    logic [4:0] digit_count;
    logic [4:0] intensity;
  } sadc_status_t;

  // digit memory access for one item
  typedef struct packed {
    logic       clear_all;
    logic       code_we;
    logic       dot_we;
    logic [3:0] wr_addr;
    logic [5:0] wr_code;
    logic [7:0] wr_dot;
    logic       rd_en;
    logic [3:0] rd_addr;
  } sadc_mem_req_t;

  // 16-segment pattern of a character code
  function automatic logic [15:0] sadc_seg(input logic [5:0] code);
    logic [15:0] s;
    case (code)
      6'd0:  s = 16'h507F; 6'd1:  s = 16'h44CF; 6'd2:  s = 16'h153F; 6'd3:  s = 16'h00F3;
      6'd4:  s = 16'h113F; 6'd5:  s = 16'h40F3; 6'd6:  s = 16'h40C3; 6'd7:  s = 16'h04FB;
      6'd8:  s = 16'h44CC; 6'd9:  s = 16'h1133; 6'd10: s = 16'h007C; 6'd11: s = 16'h4AC0;
      6'd12: s = 16'h00F0; 6'd13: s = 16'h82CC; 6'd14: s = 16'h88CC; 6'd15: s = 16'h00FF;
      6'd16: s = 16'h44C7; 6'd17: s = 16'h08FF; 6'd18: s = 16'h4CC7; 6'd19: s = 16'h44BB;
      6'd20: s = 16'h1103; 6'd21: s = 16'h00FC; 6'd22: s = 16'h22C0; 6'd23: s = 16'h28CC;
      6'd24: s = 16'hAA00; 6'd25: s = 16'h9200; 6'd26: s = 16'h2233; 6'd27: s = 16'h00E1;
      6'd28: s = 16'h8800; 6'd29: s = 16'h001E; 6'd30: s = 16'h2800; 6'd31: s = 16'h0030;
      6'd32: s = 16'h0000; 6'd33: s = 16'h8121; 6'd34: s = 16'h0180; 6'd35: s = 16'h553C;
      6'd36: s = 16'h11BB; 6'd37: s = 16'h7799; 6'd38: s = 16'hC979; 6'd39: s = 16'h0200;
      6'd40: s = 16'h0A00; 6'd41: s = 16'hA000; 6'd42: s = 16'hFF00; 6'd43: s = 16'h5500;
      6'd44: s = 16'h0000; 6'd45: s = 16'h4400; 6'd46: s = 16'h0000; 6'd47: s = 16'h2200;
      6'd48: s = 16'h22FF; 6'd49: s = 16'h1100; 6'd50: s = 16'h4477; 6'd51: s = 16'h443F;
      6'd52: s = 16'h448C; 6'd53: s = 16'h44BB; 6'd54: s = 16'h44FB; 6'd55: s = 16'h000F;
      6'd56: s = 16'h44FF; 6'd57: s = 16'h44BF; 6'd58: s = 16'h0021; 6'd59: s = 16'h2001;
      6'd60: s = 16'h4430; 6'd61: s = 16'h4430; 6'd62: s = 16'h0312; 6'd63: s = 16'h1407;
      default: s = 16'h0000;
    endcase
    return s;
  endfunction

endpackage

[rtl/core/sadc_ctrl.sv]
// ---------------------------------------------------------------------------
// sadc_ctrl
// Command decode, serial shifter and settings registers; issues digit
// memory writes and the read-out access for every transfer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sadc_ctrl
  import sadc_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_fire,
  input  sadc_in_t      in_item,
  output sadc_mem_req_t mem_req,
  output sadc_status_t  status
);

  logic       enable_r,   enable_nxt;
  logic       last_clk_r, last_clk_nxt;
  logic [7:0] shift_r,    shift_nxt;
  logic [2:0] bit_cnt_r,  bit_cnt_nxt;
  logic [3:0] cursor_r,   cursor_nxt;
  logic [4:0] digits_r,   digits_nxt;
  logic [4:0] bright_r,   bright_nxt;

  logic       byte_go;
  logic [7:0] byte_val;
  logic       pin_bit;
  logic [5:0] char_code;

  // next state and memory request
  always_comb begin
    enable_nxt   = enable_r;
    last_clk_nxt = last_clk_r;
    shift_nxt    = shift_r;
    bit_cnt_nxt  = bit_cnt_r;
    cursor_nxt   = cursor_r;
    digits_nxt   = digits_r;
    bright_nxt   = bright_r;
    byte_go      = 1'b0;
    byte_val     = in_item.data;
    pin_bit      = (in_item.data != 8'd0);
    char_code    = in_item.data[5:0];
    mem_req      = '0;
    mem_req.rd_en   = in_fire;
    mem_req.rd_addr = in_item.read_index;

    if (in_fire) begin
      case (sadc_cmd_t'(in_item.cmd))
        CMD_ENABLE: begin
          // falling enable clears the whole display
          if (!in_item.level && enable_r) begin
            mem_req.clear_all = 1'b1;
            last_clk_nxt = 1'b0;
            shift_nxt    = 8'd0;
            bit_cnt_nxt  = 3'd0;
            cursor_nxt   = CURSOR_RESET;
            digits_nxt   = DIGITS_MAX;
            bright_nxt   = 5'd0;
          end
          enable_nxt = in_item.level;
        end
        CMD_PINS: begin
          // shift on falling clock pin, MSB first
          if (enable_r && last_clk_r && !in_item.level) begin
            shift_nxt = {shift_r[6:0], pin_bit};
            if (bit_cnt_r == 3'd7) begin
              byte_go     = 1'b1;
              byte_val    = {shift_r[6:0], pin_bit};
              shift_nxt   = 8'd0;
              bit_cnt_nxt = 3'd0;
            end else begin
              bit_cnt_nxt = bit_cnt_r + 3'd1;
            end
          end
          last_clk_nxt = in_item.level;
        end
        CMD_BYTE: begin
          byte_go = enable_r;
        end
        default: ;
      endcase
    end

    // byte decode
    if (byte_go) begin
      case (byte_val[7:5])
        TOP_INTENSITY: bright_nxt = byte_val[4:0];
        TOP_CURSOR:    cursor_nxt = byte_val[3:0];
        TOP_DIGITS: begin
          if (byte_val[4:0] == 5'd0 || byte_val[4:0] > DIGITS_MAX) begin
            digits_nxt = DIGITS_MAX;
          end else begin
            digits_nxt = byte_val[4:0];
          end
        end
        TOP_TEST: ;
        default: begin
          char_code = (byte_val[5:0] == 6'd0) ? CODE_SPACE : byte_val[5:0];
          if (char_code == CODE_PERIOD || char_code == CODE_COMMA) begin
            // attach to current digit, cursor stays
            mem_req.dot_we  = 1'b1;
            mem_req.wr_addr = cursor_r;
            mem_req.wr_dot  = {2'b00, char_code};
          end else begin
            // advance and store, clearing any dot
            cursor_nxt      = cursor_r + 4'd1;
            mem_req.code_we = 1'b1;
            mem_req.dot_we  = 1'b1;
            mem_req.wr_addr = cursor_r + 4'd1;
            mem_req.wr_code = char_code;
            mem_req.wr_dot  = DOT_NONE;
          end
        end
      endcase
    end

    status.enabled     = enable_nxt;
    status.cursor      = cursor_nxt;
    status.digit_count = digits_nxt;
    status.intensity   = bright_nxt;
  end

  // settings registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r   <= 1'b0;
      last_clk_r <= 1'b0;
      shift_r    <= 8'd0;
      bit_cnt_r  <= 3'd0;
      cursor_r   <= CURSOR_RESET;
      digits_r   <= DIGITS_MAX;
      bright_r   <= 5'd0;
    end else begin
      enable_r   <= enable_nxt;
      last_clk_r <= last_clk_nxt;
      shift_r    <= shift_nxt;
      bit_cnt_r  <= bit_cnt_nxt;
      cursor_r   <= cursor_nxt;
      digits_r   <= digits_nxt;
      bright_r   <= bright_nxt;
    end
  end

endmodule

[rtl/core/sadc_digit_ram.sv]
// ---------------------------------------------------------------------------
// sadc_digit_ram
// Digit store: character and dot memories with registered read,
// per-entry valid bits for the space reset value, and write forwarding.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sadc_digit_ram
  import sadc_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  sadc_mem_req_t req,
  output logic [5:0]    rd_code,
  output logic [7:0]    rd_dot
);

  `include "serial_alphanumeric_display_controller_assert.svh"

  logic [5:0] code_mem [NUM_DIGITS];
  logic [7:0] dot_mem  [NUM_DIGITS];

  logic [NUM_DIGITS-1:0] code_vld_r, code_vld_nxt;
  logic [NUM_DIGITS-1:0] dot_vld_r,  dot_vld_nxt;

  logic [5:0] code_q_r, code_wd_r;
  logic [7:0] dot_q_r,  dot_wd_r;
  logic       code_byp_r, code_ok_r;
  logic       dot_byp_r,  dot_ok_r;

  // valid bits: clear on display reset, set on write
  always_comb begin
    code_vld_nxt = code_vld_r;
    dot_vld_nxt  = dot_vld_r;
    if (req.clear_all) begin
      code_vld_nxt = '0;
      dot_vld_nxt  = '0;
    end
    if (req.code_we) code_vld_nxt[req.wr_addr] = 1'b1;
    if (req.dot_we)  dot_vld_nxt[req.wr_addr]  = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_vld_r <= '0;
      dot_vld_r  <= '0;
    end else begin
      code_vld_r <= code_vld_nxt;
      dot_vld_r  <= dot_vld_nxt;
    end
  end

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (req.code_we) code_mem[req.wr_addr] <= req.wr_code;
    if (req.dot_we)  dot_mem[req.wr_addr]  <= req.wr_dot;
    if (req.rd_en) begin
      code_q_r   <= code_mem[req.rd_addr];
      dot_q_r    <= dot_mem[req.rd_addr];
      code_wd_r  <= req.wr_code;
      dot_wd_r   <= req.wr_dot;
      code_byp_r <= req.code_we && (req.wr_addr == req.rd_addr);
      dot_byp_r  <= req.dot_we && (req.wr_addr == req.rd_addr);
      code_ok_r  <= code_vld_nxt[req.rd_addr];
      dot_ok_r   <= dot_vld_nxt[req.rd_addr];
    end
  end

  // forward same-cycle write, unwritten entries read as reset value
  assign rd_code = code_byp_r ? code_wd_r : (code_ok_r ? code_q_r : CODE_SPACE);
  assign rd_dot  = dot_byp_r  ? dot_wd_r  : (dot_ok_r  ? dot_q_r  : DOT_NONE);

  `SADC_ASSERT_IMPL(a_char_clears_dot, clk, rst_n, req.code_we, req.dot_we)
  `SADC_ASSERT_IMPL(a_clear_no_write, clk, rst_n, req.clear_all, !req.dot_we)
  `SADC_ASSERT_NEXT(a_clear_reads_blank, clk, rst_n, req.rd_en && req.clear_all,
                    rd_code == CODE_SPACE && rd_dot == DOT_NONE)

endmodule

[rtl/core/serial_alphanumeric_display_controller.sv]
// ---------------------------------------------------------------------------
// serial_alphanumeric_display_controller
// 16-digit alphanumeric display controller: serial or byte commands update
// the digit memory and settings, each transfer returns one digit read-out.
// ---------------------------------------------------------------------------
// Result path: the digit memory read register, then segment lookup into
//   the output register.
// Throughput: one item per cycle while out_ready holds, set by the single
//   digit memory read issued with every transfer.
// Reset: rst_n synchronous, active low; settings return to defaults and all
//   digit entries are marked unwritten at once, reading as blank.
`timescale 1ns / 1ps

module serial_alphanumeric_display_controller
  import sadc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  sadc_in_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output sadc_out_t out_item
);

  `include "serial_alphanumeric_display_controller_assert.svh"

  logic          in_fire;
  logic          s1_adv;
  logic          s1_valid_r;
  sadc_status_t  s1_stat_r;
  sadc_status_t  status;
  sadc_mem_req_t mem_req;
  logic [5:0]    rd_code;
  logic [7:0]    rd_dot;
  logic          out_valid_r;
  sadc_out_t     out_item_r;

  // handshake: read stage moves on when output register is empty or being read
  assign s1_adv   = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_fire  = in_valid && in_ready;

  sadc_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_item (in_item),
    .mem_req (mem_req),
    .status  (status)
  );

  sadc_digit_ram u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mem_req),
    .rd_code (rd_code),
    .rd_dot  (rd_dot)
  );

  // read stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) s1_stat_r <= status;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_valid_r && s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && s1_adv) begin
      out_item_r.char_code   <= rd_code;
      out_item_r.dot_comma   <= rd_dot;
      out_item_r.segments    <= sadc_seg(rd_code);
      out_item_r.intensity   <= s1_stat_r.intensity;
      out_item_r.digit_count <= s1_stat_r.digit_count;
      out_item_r.cursor      <= s1_stat_r.cursor;
      out_item_r.enabled     <= s1_stat_r.enabled;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `SADC_ASSERT_NEXT(a_fire_fills_s1, clk, rst_n, in_fire, s1_valid_r)
  `SADC_ASSERT_NEXT(a_s1_drains, clk, rst_n, s1_valid_r && !out_valid_r, out_valid_r)
  `SADC_ASSERT_IMPL(a_stall_blocks_in, clk, rst_n, s1_valid_r && !s1_adv, !in_ready)
  `SADC_ASSERT_IMPL(a_digits_range, clk, rst_n, out_valid_r,
                    out_item_r.digit_count != 5'd0 && out_item_r.digit_count <= DIGITS_MAX)

endmodule
